### src/stwp_pkg.sv
// ----------------------------------------------------------------------------
// stwp_pkg
// Shared constants and types of the sorted table weighted pick block.
// ----------------------------------------------------------------------------
`default_nettype none
package stwp_pkg;
  localparam int unsigned TableDepth = 1024;
  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned CntW = IdxW + 1;
  localparam int unsigned EntryW = 64 + 16 + 16 + 16;
  localparam int unsigned SumW = 16 + IdxW;

  localparam logic [1:0] CfgEntryCount = 2'd0;
  localparam logic [1:0] CfgMinScore = 2'd1;
  localparam logic [1:0] CfgRngSeed = 2'd2;

  typedef struct packed {
    logic [63:0] key;
    logic [15:0] move;
    logic [15:0] weight;
    logic [15:0] score;
  } entry_t;

  function automatic logic [63:0] xorshift(input logic [63:0] x);
    logic [63:0] y;
    y = x ^ (x << 13);
    y = y ^ (y >> 7);
    y = y ^ (y << 17);
    return y;
  endfunction
endpackage
`default_nettype wire

### src/stwp_ram.sv
// ----------------------------------------------------------------------------
// stwp_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module stwp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

### src/stwp_mod.sv
// ----------------------------------------------------------------------------
// stwp_mod
// Restoring remainder unit: 64-bit word mod a sum, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module stwp_mod (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [63:0]                   num_i,
  input  wire logic [stwp_pkg::SumW-1:0]     den_i,
  output logic                               done_o,
  output logic      [stwp_pkg::SumW-1:0]     rem_o
);
  import stwp_pkg::*;

  logic [63:0]   num_q, num_d;
  logic [SumW:0] rem_q, rem_d;
  logic [SumW-1:0] den_q, den_d;
  logic [6:0]    cnt_q, cnt_d;
  logic          run_q, run_d;
  logic [SumW:0] sh;

  always_comb begin
    num_d = num_q;
    rem_d = rem_q;
    den_d = den_q;
    cnt_d = cnt_q;
    run_d = run_q;
    done_o = 1'b0;
    sh = {rem_q[SumW-1:0], num_q[63]};
    if (start_i) begin
      num_d = num_i;
      den_d = den_i;
      rem_d = '0;
      cnt_d = 7'd0;
      run_d = 1'b1;
    end else if (run_q) begin
      num_d = {num_q[62:0], 1'b0};
      rem_d = (sh >= {1'b0, den_q}) ? sh - {1'b0, den_q} : sh;
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        run_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  assign rem_o = rem_d[SumW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end
endmodule
`default_nettype wire

### src/sorted_table_weighted_pick.sv
// ----------------------------------------------------------------------------
// sorted_table_weighted_pick
// Sorted table with lower-bound search and weighted random pick.
// ----------------------------------------------------------------------------
// A load item writes one entry. A probe runs a lower-bound search (log2 of
// entry_count steps), then reads each matching entry and runs the bit-serial
// remainder unit for each that passes the score test. One item is worked on
// at a time; busy is high meanwhile. Results cannot be stalled. Reset clears
// control state and sets rng_q to 1; the table is undefined until loaded.
`default_nettype none
module sorted_table_weighted_pick (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire logic        mode_i,
  input  wire logic [stwp_pkg::IdxW-1:0] entry_index_i,
  input  wire logic [63:0] probe_key_i,
  input  wire logic [15:0] entry_move_i,
  input  wire logic [15:0] entry_weight_i,
  input  wire logic signed [15:0] entry_score_i,
  input  wire logic        prefer_best_i,
  output logic             result_valid_o,
  output logic             picked_o,
  output logic [15:0]      picked_move_o,
  output logic signed [15:0] picked_score_o
);
  import stwp_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StSrch = 3'd1;
  localparam logic [2:0] StSrchW = 3'd2;
  localparam logic [2:0] StScan = 3'd3;
  localparam logic [2:0] StScanW = 3'd4;
  localparam logic [2:0] StMod = 3'd5;
  localparam logic [2:0] StDone = 3'd6;

  logic [2:0] st_q, st_d;
  logic [CntW-1:0] cnt_q, n_eff;
  logic [15:0] min_q;
  logic [63:0] rng_q, rng_d;
  logic [63:0] key_q, key_d;
  logic best_mode_q, best_mode_d;
  logic [CntW-1:0] lo_q, lo_d, hi_q, hi_d, mid;
  logic [15:0] best_q, best_d, cw_q, cw_d;
  logic [SumW-1:0] sum_q, sum_d, sum_n;
  logic pk_q, pk_d;
  logic [15:0] pm_q, pm_d, ps_q, ps_d;
  logic rv_q, rv_d;
  logic we;
  logic [IdxW-1:0] addr;
  entry_t wr, rd;
  logic mod_start, mod_done, mod_go_q;
  logic [SumW-1:0] rem;
  logic [15:0] nbest;

  assign cfg_ready_o = 1'b1;
  assign busy = (st_q != StIdle);
  assign n_eff = (cnt_q > CntW'(TableDepth)) ? CntW'(TableDepth) : cnt_q;
  assign mid = (lo_q + hi_q) >> 1;
  assign wr = '{key: probe_key_i, move: entry_move_i, weight: entry_weight_i,
                score: entry_score_i};

  stwp_ram #(.Width(EntryW), .Depth(TableDepth)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wr), .rdata_o(rd));

  stwp_mod u_mod (
    .clk_i, .rst_ni, .start_i(mod_go_q), .num_i(rng_q), .den_i(sum_q),
    .done_o(mod_done), .rem_o(rem));

  always_comb begin
    st_d = st_q; key_d = key_q; best_mode_d = best_mode_q;
    lo_d = lo_q; hi_d = hi_q; best_d = best_q; sum_d = sum_q; cw_d = cw_q;
    pk_d = pk_q; pm_d = pm_q; ps_d = ps_q; rv_d = 1'b0; rng_d = rng_q;
    we = 1'b0; addr = mid[IdxW-1:0]; mod_start = 1'b0;
    nbest = (rd.weight > best_q) ? rd.weight : best_q;
    sum_n = sum_q + SumW'(rd.weight);
    if (cfg_valid_i && cfg_index_i == CfgRngSeed) rng_d = cfg_data_i;
    unique case (st_q)
      StIdle: begin
        addr = entry_index_i;
        if (start) begin
          if (!mode_i) begin
            we = 1'b1;
          end else begin
            key_d = probe_key_i; best_mode_d = prefer_best_i;
            lo_d = '0; hi_d = n_eff - CntW'(1);
            best_d = '0; sum_d = '0; pk_d = 1'b0; pm_d = '0; ps_d = '0;
            st_d = (n_eff == '0) ? StDone : StSrch;
          end
        end
      end
      StSrch: begin
        if (lo_q < hi_q) st_d = StSrchW;
        else begin addr = lo_q[IdxW-1:0]; st_d = StScanW; end
      end
      StSrchW: begin
        if (key_q <= rd.key) hi_d = mid; else lo_d = mid + CntW'(1);
        st_d = StSrch;
      end
      StScan: begin
        addr = lo_q[IdxW-1:0];
        st_d = (lo_q < n_eff) ? StScanW : StDone;
      end
      StScanW: begin
        addr = lo_q[IdxW-1:0];
        if (rd.key != key_q) st_d = StDone;
        else begin
          best_d = nbest; sum_d = sum_n; cw_d = rd.weight;
          if ($signed(min_q) <= $signed(rd.score)) begin
            rng_d = xorshift(rng_q);
            st_d = StMod;
            mod_start = 1'b1;
          end else begin
            lo_d = lo_q + CntW'(1); st_d = StScan;
          end
        end
      end
      StMod: begin
        addr = lo_q[IdxW-1:0];
        if (mod_done) begin
          if (((sum_q != '0) && (rem < SumW'(cw_q))) ||
              (best_mode_q && cw_q == best_q)) begin
            pk_d = 1'b1; pm_d = rd.move; ps_d = rd.score;
          end
          lo_d = lo_q + CntW'(1); st_d = StScan;
        end
      end
      StDone: begin rv_d = 1'b1; st_d = StIdle; end
      default: st_d = StIdle;
    endcase
  end

  // The remainder unit starts in the cycle after the draw, once rng_q holds the
  // new word and sum_q includes the weight of the current entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; cnt_q <= '0; min_q <= '0; rng_q <= 64'd1; rv_q <= 1'b0;
      mod_go_q <= 1'b0;
    end else begin
      st_q <= st_d; rng_q <= rng_d; rv_q <= rv_d; mod_go_q <= mod_start;
      if (cfg_valid_i && cfg_index_i == CfgEntryCount) cnt_q <= cfg_data_i[CntW-1:0];
      if (cfg_valid_i && cfg_index_i == CfgMinScore) min_q <= cfg_data_i[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d; best_mode_q <= best_mode_d; lo_q <= lo_d; hi_q <= hi_d;
    best_q <= best_d; sum_q <= sum_d; cw_q <= cw_d;
    pk_q <= pk_d; pm_q <= pm_d; ps_q <= ps_d;
  end

  assign result_valid_o = rv_q;
  assign picked_o = pk_q;
  assign picked_move_o = pm_q;
  assign picked_score_o = ps_q;
endmodule
`default_nettype wire
